// ===== src/scale_quantizer_hysteresis_core_assert.svh =====
// Assertion macros for the RTL
`ifndef SCALE_QUANTIZER_HYSTERESIS_CORE_ASSERT_SVH
`define SCALE_QUANTIZER_HYSTERESIS_CORE_ASSERT_SVH
`define SQH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SQH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/sqh_pkg.sv =====
`default_nettype none
package sqh_pkg;
   localparam int SCALE_ENTRIES_DEF = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIVISIONS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OCTAVE_MV = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NOTES_0_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NOTES_4_7 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NOTES_8_11 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NOTES_12_15 = 3'd6;
   localparam int DIV_W = 48;   // serial divider dividend/result width

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_OCT, ST_OCT_FIX, ST_IDX_MUL, ST_IDX, ST_ENTRY,
      ST_VOLT, ST_VOLT_FIX, ST_BOUND, ST_WIN, ST_HYST, ST_PLACE, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage
`default_nettype wire

// ===== src/sqh_if.sv =====
`default_nettype none
interface sqh_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] level_mv;
   modport source (output valid, output level_mv, input ready);
   modport sink (input valid, input level_mv, output ready);
endinterface

interface sqh_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [9:0]  octave;
   logic        [3:0]  scale_index;
   logic signed [26:0] note_q8;
   logic signed [15:0] volts_mv;
   modport source (output valid, output octave, output scale_index, output note_q8,
                   output volts_mv, input ready);
   modport sink (input valid, input octave, input scale_index, input note_q8,
                 input volts_mv, output ready);
endinterface
`default_nettype wire

// ===== src/sqh_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, unsigned.
module sqh_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [sqh_pkg::DIV_W-1:0]        dividend,
   input  wire logic [23:0]                      divisor,
   output sqh_pkg::div_ctl_type                  ctl,
   output logic      [sqh_pkg::DIV_W-1:0]        quotient,
   output logic      [23:0]                      remainder
);
   localparam int CW = $clog2(sqh_pkg::DIV_W + 1);
   logic [sqh_pkg::DIV_W-1:0] q_ff, q_in;
   logic [24:0] r_ff, r_in;
   logic [23:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [24:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = '0;
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CW'(sqh_pkg::DIV_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff[23:0], q_ff[sqh_pkg::DIV_W-1]};
         q_in = {q_ff[sqh_pkg::DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff[23:0];
endmodule
`default_nettype wire

// ===== src/sqh_mul.sv =====
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle, signed multiplicand.
module sqh_mul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [47:0] mcand,
   input  wire logic        [23:0] mplier,
   output logic                    done,
   output logic signed [47:0]      product
);
   logic signed [47:0] acc_ff, acc_in, a_ff, a_in;
   logic [23:0] m_ff, m_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff; a_in = a_ff; m_in = m_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         acc_in = '0; a_in = mcand; m_in = mplier; cnt_in = 5'd24; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (m_ff[0]) acc_in = acc_ff + a_ff;
         a_in = a_ff <<< 1;
         m_in = m_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in; a_ff <= a_in; m_ff <= m_in;
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// ===== src/scale_quantizer_hysteresis_core.sv =====
`default_nettype none
// Pitch quantizer with hysteresis.
// req channel: one signed millivolt sample per transfer. rsp channel: octave,
// scale index, Q19.8 note and ideal millivolts, one transfer per sample that
// left the hysteresis window; samples inside it produce no transfer.
// csr port: write enable, index, 64-bit data; any valid write re-places the
// window at octave -10 index 0. Write only while idle.
// One sample at a time. A sample inside the window goes straight back to idle
// from the check state. A sample outside runs a bit-serial divider seven times
// and a bit-serial multiplier three times; the result is registered after the
// voltage step, and the next sample is taken once the window has been re-placed
// around it. Re-placing the window after a csr write or reset runs the divider
// three times and the multiplier once, during which req is held off.
// Reset: registers take their defaults and the window is re-placed.
// A result waits in the output register while rsp.ready is low; the next
// sample is taken only once it is gone.
module scale_quantizer_hysteresis_core #(
   parameter int SCALE_ENTRIES = sqh_pkg::SCALE_ENTRIES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sqh_req_if.sink                               req,
   sqh_rsp_if.source                             rsp,
   input  wire logic                             csr_we,
   input  wire logic [sqh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sqh_pkg::CSR_DATA_W-1:0]   csr_data
);
   `include "scale_quantizer_hysteresis_core_assert.svh"
   localparam int LW = $clog2(SCALE_ENTRIES + 1);

   sqh_pkg::state_type st_ff, st_in;
   logic [4:0]  slen_ff;
   logic [7:0]  divs_ff;
   logic [14:0] omv_ff;
   logic [63:0] notes_ff [4];
   logic signed [31:0] lo_ff, hi_ff;
   logic signed [31:0] lvl_ff;
   logic signed [47:0] x_ff, t_ff;
   logic signed [9:0]  oct_ff;
   logic [3:0] idx_ff;
   logic [15:0] entry_ff;
   logic [23:0] win_ff, off_ff;
   logic [2:0] step_ff;
   logic pend_ff;
   logic rv_ff;
   logic signed [9:0]  r_oct_ff;
   logic [3:0]  r_idx_ff;
   logic signed [26:0] r_note_ff;
   logic signed [15:0] r_mv_ff;

   // effective configuration
   logic [7:0]  e_divs;
   logic [14:0] e_omv;
   logic [23:0] span;
   logic [4:0]  len_raw;
   logic [LW-1:0] e_len;
   always_comb begin
      e_divs = (divs_ff == 8'd0) ? 8'd1 : divs_ff;
      e_omv = (omv_ff < 15'd100) ? 15'd100 : omv_ff;
      span = {1'b0, e_omv, 8'd0};
      if (slen_ff == 5'd0) len_raw = (e_divs > 8'd16) ? 5'd16 : e_divs[4:0];
      else len_raw = slen_ff;
      if (len_raw > 5'(SCALE_ENTRIES)) e_len = LW'(SCALE_ENTRIES);
      else if (len_raw == 5'd0) e_len = LW'(1);
      else e_len = LW'(len_raw);
   end

   // shared serial units
   logic dv_go, ml_go, ml_done;
   logic [sqh_pkg::DIV_W-1:0] dv_num, dv_q;
   logic [23:0] dv_den, dv_r;
   sqh_pkg::div_ctl_type dv_ctl;
   logic signed [47:0] ml_a, ml_p;
   logic [23:0] ml_b;
   sqh_div u_div (.clock, .reset, .start(dv_go), .dividend(dv_num), .divisor(dv_den),
      .ctl(dv_ctl), .quotient(dv_q), .remainder(dv_r));
   sqh_mul u_mul (.clock, .reset, .start(ml_go), .mcand(ml_a), .mplier(ml_b),
      .done(ml_done), .product(ml_p));

   logic cfg_hit;
   logic signed [31:0] lvl;
   logic outside;
   logic [3:0] eidx;
   logic [15:0] entry_sel;
   logic [23:0] hyst;
   assign cfg_hit = csr_we && (csr_index <= sqh_pkg::REG_NOTES_12_15);
   assign lvl = 32'(req.level_mv) <<< 8;
   // a sample on a bound counts as inside
   assign outside = (lvl_ff > hi_ff) || (lvl_ff < lo_ff);
   assign eidx = idx_ff;
   always_comb begin
      if (slen_ff == 5'd0) entry_sel = {eidx, 8'd0};
      else entry_sel = notes_ff[eidx[3:2]][16*eidx[1:0] +: 16];
      hyst = (dv_q[23:0] < 24'd1536) ? 24'd1536 : dv_q[23:0];
   end

   // step counter drives sub-phases inside the states (start, wait)
   logic dv_fin;
   assign dv_fin = dv_ctl.done;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         sqh_pkg::ST_IDLE:
            if (pend_ff) st_in = sqh_pkg::ST_BOUND;
            else if (req.valid && req.ready) st_in = sqh_pkg::ST_CHECK;
         sqh_pkg::ST_CHECK:
            if (!outside) st_in = sqh_pkg::ST_IDLE;
            else if (dv_fin) st_in = sqh_pkg::ST_OCT;
         sqh_pkg::ST_OCT:    if (dv_fin) st_in = sqh_pkg::ST_OCT_FIX;
         sqh_pkg::ST_OCT_FIX: st_in = sqh_pkg::ST_IDX_MUL;
         sqh_pkg::ST_IDX_MUL: if (ml_done) st_in = sqh_pkg::ST_IDX;
         sqh_pkg::ST_IDX:    if (dv_fin) st_in = sqh_pkg::ST_ENTRY;
         sqh_pkg::ST_ENTRY:  if (ml_done) st_in = sqh_pkg::ST_VOLT;
         sqh_pkg::ST_VOLT:   if (dv_fin) st_in = sqh_pkg::ST_VOLT_FIX;
         sqh_pkg::ST_VOLT_FIX: st_in = sqh_pkg::ST_BOUND;
         sqh_pkg::ST_BOUND:  if (dv_fin) st_in = sqh_pkg::ST_WIN;
         sqh_pkg::ST_WIN:    if (dv_fin) st_in = sqh_pkg::ST_HYST;
         sqh_pkg::ST_HYST:   if (dv_fin) st_in = sqh_pkg::ST_PLACE;
         sqh_pkg::ST_PLACE:  if (ml_done) st_in = sqh_pkg::ST_DONE;
         sqh_pkg::ST_DONE:   st_in = sqh_pkg::ST_IDLE;
         default:            st_in = sqh_pkg::ST_IDLE;
      endcase
   end

   // unit start strobes and operands
   always_comb begin
      dv_go = 1'b0; ml_go = 1'b0;
      dv_num = '0; dv_den = 24'd1; ml_a = '0; ml_b = '0;
      unique case (st_ff)
         sqh_pkg::ST_CHECK: begin
            // offset = omv*128/divs
            dv_go = (step_ff == 3'd0) && outside;
            dv_num = 48'({e_omv, 7'd0}); dv_den = 24'(e_divs);
         end
         sqh_pkg::ST_OCT: begin
            dv_go = (step_ff == 3'd0);
            dv_num = x_ff[47] ? 48'(-x_ff) : 48'(x_ff); dv_den = span;
         end
         sqh_pkg::ST_IDX_MUL: begin
            ml_go = (step_ff == 3'd0); ml_a = t_ff; ml_b = 24'(e_len);
         end
         sqh_pkg::ST_IDX: begin
            dv_go = (step_ff == 3'd0); dv_num = 48'(t_ff); dv_den = span;
         end
         sqh_pkg::ST_ENTRY: begin
            ml_go = (step_ff == 3'd0); ml_a = 48'(entry_sel); ml_b = 24'(e_omv);
         end
         sqh_pkg::ST_VOLT: begin
            dv_go = (step_ff == 3'd0); dv_num = 48'(t_ff); dv_den = 24'(e_divs);
         end
         sqh_pkg::ST_BOUND: begin
            dv_go = (step_ff == 3'd0);
            dv_num = 48'({e_omv, 7'd0}); dv_den = 24'(e_divs);
         end
         sqh_pkg::ST_WIN: begin
            dv_go = (step_ff == 3'd0); dv_num = 48'(span); dv_den = 24'(e_len);
         end
         sqh_pkg::ST_HYST: begin
            dv_go = (step_ff == 3'd0); dv_num = 48'(win_ff); dv_den = 24'd20;
         end
         sqh_pkg::ST_PLACE: begin
            ml_go = (step_ff == 3'd0); ml_a = 48'(oct_ff); ml_b = span;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sqh_pkg::ST_IDLE; step_ff <= '0; pend_ff <= 1'b1; rv_ff <= 1'b0;
         slen_ff <= '0; divs_ff <= 8'd12; omv_ff <= 15'd1000;
         for (int i = 0; i < 4; i++) notes_ff[i] <= '0;
         oct_ff <= -10'sd10; idx_ff <= '0;
      end else begin
         st_ff <= st_in;
         step_ff <= (st_in != st_ff) ? 3'd0 : 3'd1;
         if (rsp.valid && rsp.ready) rv_ff <= 1'b0;
         if (cfg_hit) begin
            pend_ff <= 1'b1; oct_ff <= -10'sd10; idx_ff <= '0;
            unique case (csr_index)
               sqh_pkg::REG_SCALE_LENGTH: slen_ff <= csr_data[4:0];
               sqh_pkg::REG_DIVISIONS:    divs_ff <= csr_data[7:0];
               sqh_pkg::REG_OCTAVE_MV:    omv_ff <= csr_data[14:0];
               sqh_pkg::REG_NOTES_0_3:    notes_ff[0] <= csr_data;
               sqh_pkg::REG_NOTES_4_7:    notes_ff[1] <= csr_data;
               sqh_pkg::REG_NOTES_8_11:   notes_ff[2] <= csr_data;
               sqh_pkg::REG_NOTES_12_15:  notes_ff[3] <= csr_data;
               default: ;
            endcase
         end else if (st_ff == sqh_pkg::ST_IDLE) begin
            pend_ff <= 1'b0;
         end
         unique case (st_ff)
            sqh_pkg::ST_IDLE: if (req.valid && req.ready) lvl_ff <= lvl;
            sqh_pkg::ST_CHECK:
               if (dv_fin) x_ff <= 48'(lvl_ff) + 48'(dv_q[23:0]);
            sqh_pkg::ST_OCT:
               if (dv_fin) begin
                  // floor for negative dividends
                  if (!x_ff[47]) oct_ff <= 10'(dv_q);
                  else oct_ff <= 10'(-$signed(dv_q) - ((dv_r != 0) ? 48'sd1 : 48'sd0));
               end
            sqh_pkg::ST_OCT_FIX: begin
               // offset within the octave, from the divider remainder
               t_ff <= !x_ff[47] ? 48'(dv_r) : (dv_r != 24'd0) ? 48'(span - dv_r) : '0;
               r_oct_ff <= oct_ff;
            end
            sqh_pkg::ST_IDX_MUL: if (ml_done) t_ff <= ml_p;
            sqh_pkg::ST_IDX:
               if (dv_fin) begin
                  if (dv_q >= 48'(e_len)) idx_ff <= 4'(e_len - 1'b1);
                  else idx_ff <= dv_q[3:0];
               end
            sqh_pkg::ST_ENTRY:
               if (ml_done) begin
                  entry_ff <= entry_sel; t_ff <= ml_p;
               end
            sqh_pkg::ST_VOLT: if (dv_fin) t_ff <= 48'(dv_q);
            sqh_pkg::ST_VOLT_FIX: begin
               automatic logic signed [33:0] base = oct_ff * $signed({1'b0, span});
               automatic logic signed [47:0] vq = 48'(base) + t_ff;
               automatic logic signed [39:0] mv = 40'(vq >>> 8);
               r_idx_ff <= idx_ff;
               r_note_ff <= 27'(oct_ff) * 27'({e_divs, 8'd0}) + 27'(entry_ff);
               if (mv > 40'sd32767) r_mv_ff <= 16'sd32767;
               else if (mv < -40'sd32768) r_mv_ff <= -16'sd32768;
               else r_mv_ff <= mv[15:0];
               rv_ff <= 1'b1;
            end
            sqh_pkg::ST_BOUND: if (dv_fin) off_ff <= dv_q[23:0];
            sqh_pkg::ST_WIN:   if (dv_fin) win_ff <= dv_q[23:0];
            sqh_pkg::ST_HYST:  if (dv_fin) t_ff <= 48'(hyst);
            sqh_pkg::ST_PLACE:
               if (ml_done) begin
                  automatic logic signed [47:0] ideal = ml_p
                     + 48'(idx_ff) * 48'(win_ff) - 48'(off_ff);
                  lo_ff <= 32'(ideal - t_ff);
                  hi_ff <= 32'(ideal + t_ff + 48'(win_ff));
               end
            default: ;
         endcase
      end
   end

   assign req.ready = (st_ff == sqh_pkg::ST_IDLE) && !pend_ff && !rv_ff && !cfg_hit;
   assign rsp.valid = rv_ff;
   assign rsp.octave = r_oct_ff;
   assign rsp.scale_index = r_idx_ff;
   assign rsp.note_q8 = r_note_ff;
   assign rsp.volts_mv = r_mv_ff;

   `SQH_ASSERT_IMPL(a_ready_idle, clock, reset, req.ready, st_ff == sqh_pkg::ST_IDLE)
   `SQH_ASSERT_IMPL(a_no_two_units, clock, reset, dv_go, !ml_go)
   `SQH_ASSERT_NEXT(a_rsp_after_fix, clock, reset,
      st_ff == sqh_pkg::ST_VOLT_FIX, rsp.valid)
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   localparam logic [sqh_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 500;
   localparam int LONG_HOLD_CYCLES = 2000;
   localparam int NUM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 190;

   typedef struct {
      logic signed [9:0]  octave;
      logic        [3:0]  scale_index;
      logic signed [26:0] note_q8;
      logic signed [15:0] volts_mv;
   } pitch_type;

   typedef enum {ROW_LEVEL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      logic [sqh_pkg::CSR_IDX_W-1:0]  index;
      logic [63:0]                    data;
      logic signed [15:0]             level;
      bit                             typed;
      pitch_type                      want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_we;
   logic [sqh_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sqh_pkg::CSR_DATA_W-1:0] csr_data;

   sqh_req_if req ();
   sqh_rsp_if rsp ();

   scale_quantizer_hysteresis_core dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // quantizer model state
   logic [4:0]  q_len_reg;
   logic [7:0]  q_divs_reg;
   logic [14:0] q_oct_mv_reg;
   logic [63:0] q_notes [4];
   int          win_lo, win_hi;

   pitch_type pending_pitches [$];
   int     errors = 0;
   int     n_levels = 0, n_pitches = 0, n_csr = 0;
   bit     quiet = 1'b0;
   bit     long_hold = 1'b0;

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint eff_divs();
      return (q_divs_reg == 0) ? 1 : longint'(q_divs_reg);
   endfunction

   function automatic longint eff_oct_mv();
      return (q_oct_mv_reg < 100) ? 100 : longint'(q_oct_mv_reg);
   endfunction

   function automatic longint eff_len();
      longint n;
      if (q_len_reg == 0) begin
         n = eff_divs();
         if (n > 16) n = 16;
      end else begin
         n = longint'(q_len_reg);
      end
      if (n > sqh_pkg::SCALE_ENTRIES_DEF) n = sqh_pkg::SCALE_ENTRIES_DEF;
      if (n < 1) n = 1;
      return n;
   endfunction

   function automatic longint half_step();
      return (eff_oct_mv() * 128) / eff_divs();
   endfunction

   function automatic void place_window(longint ix, longint oct);
      longint span, win, hyst, ideal;
      span = eff_oct_mv() * 256;
      win = span / eff_len();
      hyst = win / 20;
      if (hyst < 1536) hyst = 1536;
      ideal = oct * span + ix * win - half_step();
      win_lo = int'(ideal - hyst);
      win_hi = int'(ideal + hyst + win);
   endfunction

   function automatic longint scale_entry(longint ix);
      logic [3:0]  k;
      logic [63:0] w;
      k = ix[3:0];
      if (q_len_reg == 0) return longint'(k) << 8;
      w = q_notes[k[3:2]] >> (16 * k[1:0]);
      return longint'(w[15:0]);
   endfunction

   function automatic void apply_csr(logic [sqh_pkg::CSR_IDX_W-1:0] idx,
                                     logic [63:0] val);
      case (idx)
         sqh_pkg::REG_SCALE_LENGTH: q_len_reg = val[4:0];
         sqh_pkg::REG_DIVISIONS:    q_divs_reg = val[7:0];
         sqh_pkg::REG_OCTAVE_MV:    q_oct_mv_reg = val[14:0];
         sqh_pkg::REG_NOTES_0_3:    q_notes[0] = val;
         sqh_pkg::REG_NOTES_4_7:    q_notes[1] = val;
         sqh_pkg::REG_NOTES_8_11:   q_notes[2] = val;
         sqh_pkg::REG_NOTES_12_15:  q_notes[3] = val;
         default: return;
      endcase
      place_window(0, -10);
   endfunction

   // returns 1 when the sample leaves the window and yields a pitch
   function automatic bit quantize(logic signed [15:0] lv, output pitch_type p);
      longint lvl, span, len, divs, x, oct, idx, entry, note, vq, mv;
      lvl = longint'(lv) * 256;
      p = '{default: '0};
      if (!(lvl > win_hi || lvl < win_lo)) return 0;
      span = eff_oct_mv() * 256;
      len = eff_len();
      divs = eff_divs();
      x = lvl + half_step();
      oct = floor_div(x, span);
      idx = ((x - oct * span) * len) / span;
      if (idx > len - 1) idx = len - 1;
      if (idx < 0) idx = 0;
      entry = scale_entry(idx);
      note = oct * divs * 256 + entry;
      vq = oct * span + (entry * eff_oct_mv()) / divs;
      mv = floor_div(vq, 256);
      if (mv > 32767) mv = 32767;
      if (mv < -32768) mv = -32768;
      p.octave = oct[9:0];
      p.scale_index = idx[3:0];
      p.note_q8 = note[26:0];
      p.volts_mv = mv[15:0];
      place_window(idx, oct);
      return 1;
   endfunction

   task automatic report(string what);
      $display("%0t MISMATCH: %s", $realtime, what);
      errors++;
   endtask

   always @(posedge clock) begin
      pitch_type w;
      if (!reset && rsp.valid && rsp.ready) begin
         n_pitches++;
         if (pending_pitches.size() == 0) begin
            report($sformatf("unexpected transfer oct=%0d idx=%0d", rsp.octave,
                             rsp.scale_index));
         end else begin
            w = pending_pitches.pop_front();
            if (rsp.octave !== w.octave)
               report($sformatf("octave %0d want %0d", rsp.octave, w.octave));
            if (rsp.scale_index !== w.scale_index)
               report($sformatf("scale_index %0d want %0d", rsp.scale_index,
                                w.scale_index));
            if (rsp.note_q8 !== w.note_q8)
               report($sformatf("note_q8 %0d want %0d", rsp.note_q8, w.note_q8));
            if (rsp.volts_mv !== w.volts_mv)
               report($sformatf("volts_mv %0d want %0d", rsp.volts_mv, w.volts_mv));
         end
      end
   end

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         if (long_hold) begin
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic wait_idle();
      while (pending_pitches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [sqh_pkg::CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_csr(idx, val);
      n_csr++;
   endtask

   task automatic send_level(logic signed [15:0] lv, bit typed, pitch_type want);
      pitch_type p;
      req.valid <= 1'b1;
      req.level_mv <= lv;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      n_levels++;
      if (quantize(lv, p)) pending_pitches.push_back(typed ? want : p);
      else if (typed) report($sformatf("level %0d stayed inside window", lv));
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic row_type lvl_row(logic signed [15:0] lv);
      return '{kind: ROW_LEVEL, index: '0, data: '0, level: lv, typed: 0,
               want: '{default: '0}};
   endfunction

   function automatic row_type csr_row(logic [sqh_pkg::CSR_IDX_W-1:0] idx,
                                       logic [63:0] val);
      return '{kind: ROW_CSR, index: idx, data: val, level: '0, typed: 0,
               want: '{default: '0}};
   endfunction

   function automatic row_type typed_row(logic signed [15:0] lv, int oct, int ix,
                                         int note, int mv);
      row_type r;
      r = lvl_row(lv);
      r.typed = 1;
      r.want.octave = oct[9:0];
      r.want.scale_index = ix[3:0];
      r.want.note_q8 = note[26:0];
      r.want.volts_mv = mv[15:0];
      return r;
   endfunction

   initial begin
      row_type   rows [$];
      pitch_type none;
      logic signed [15:0] lv;
      int     step;
      none = '{default: '0};
      req.valid <= 1'b0;
      req.level_mv <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      q_len_reg = 0;
      q_divs_reg = 12;
      q_oct_mv_reg = 1000;
      foreach (q_notes[i]) q_notes[i] = '0;
      place_window(0, -10);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // defaults: chromatic 12-step, 1000 mV per octave
      rows.push_back(typed_row(16'sd0, 0, 0, 0, 0));
      rows.push_back(lvl_row(16'sd0));
      rows.push_back(typed_row(16'sd32767, 32, 9, 100608, 32750));
      rows.push_back(typed_row(-16'sd32768, -33, 3, -100608, -32750));
      // one division: window edges land on whole millivolts (+-550)
      rows.push_back(csr_row(sqh_pkg::REG_DIVISIONS, 64'd1));
      rows.push_back(lvl_row(16'sd0));
      rows.push_back(lvl_row(-16'sd550));
      rows.push_back(lvl_row(16'sd550));
      rows.push_back(lvl_row(16'sd551));
      rows.push_back(lvl_row(-16'sd551));
      rows.push_back(csr_row(sqh_pkg::REG_DIVISIONS, 64'd0));
      rows.push_back(csr_row(sqh_pkg::REG_OCTAVE_MV, 64'd50));
      rows.push_back(lvl_row(16'sd1234));
      rows.push_back(csr_row(sqh_pkg::REG_OCTAVE_MV, 64'h7FFF));
      rows.push_back(csr_row(sqh_pkg::REG_SCALE_LENGTH, 64'd31));
      rows.push_back(csr_row(sqh_pkg::REG_NOTES_0_3, 64'hFFFF_8000_0100_0000));
      rows.push_back(csr_row(sqh_pkg::REG_NOTES_4_7, '1));
      rows.push_back(csr_row(sqh_pkg::REG_NOTES_8_11, 64'h0123_4567_89AB_CDEF));
      rows.push_back(csr_row(sqh_pkg::REG_NOTES_12_15, 64'hFEDC_BA98_7654_3210));
      rows.push_back(lvl_row(16'sd32767));
      rows.push_back(lvl_row(-16'sd32768));
      rows.push_back(csr_row(REG_UNUSED, '1));
      rows.push_back(lvl_row(-16'sd1));
      rows.push_back(csr_row(sqh_pkg::REG_DIVISIONS, 64'd255));
      rows.push_back(csr_row(sqh_pkg::REG_OCTAVE_MV, 64'd100));
      rows.push_back(lvl_row(16'sd0));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            req.valid <= 1'b0;
            wait_idle();
            write_csr(rows[i].index, rows[i].data);
         end else begin
            send_level(rows[i].level, rows[i].typed, rows[i].want);
         end
      end

      lv = 0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         req.valid <= 1'b0;
         wait_idle();
         quiet = (ph == NUM_PHASES - 1);
         write_csr(sqh_pkg::REG_SCALE_LENGTH, ph == 1 ? 64'd16 : ph == 2 ? 64'd1 :
                   ph == 3 ? 64'd0 : 64'($urandom_range(0, 31)));
         write_csr(sqh_pkg::REG_DIVISIONS, ph == 1 ? 64'd255 : ph == 2 ? 64'd1 :
                   64'($urandom_range(0, 255)));
         write_csr(sqh_pkg::REG_OCTAVE_MV, ph == 1 ? 64'd100 : ph == 2 ? 64'h7FFF :
                   ph == 4 ? 64'($urandom_range(0, 99)) :
                   64'($urandom_range(100, 4000)));
         write_csr(sqh_pkg::REG_NOTES_0_3, {$urandom, $urandom});
         write_csr(sqh_pkg::REG_NOTES_4_7, {$urandom, $urandom});
         write_csr(sqh_pkg::REG_NOTES_8_11, {$urandom, $urandom});
         write_csr(sqh_pkg::REG_NOTES_12_15, {$urandom, $urandom});
         if (ph == 2) long_hold = 1'b1;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if ($urandom_range(0, 9) < 3) begin
               lv = 16'($urandom);
            end else begin
               // slow walk so the window is crossed often and stays nearby
               step = int'(lv) + int'($urandom_range(0, 600)) - 300;
               if (step > 32767) step = 32767;
               if (step < -32768) step = -32768;
               lv = step[15:0];
            end
            send_level(lv, 0, none);
         end
      end
      req.valid <= 1'b0;
      wait_idle();

      $display("Covered %0d samples, %0d pitch transfers, %0d register writes,",
               n_levels, n_pitches, n_csr);
      $display("chromatic and custom scales, extreme divisions and octave spans.");
      if (errors == 0 && pending_pitches.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb_top failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/sqh_pkg.sv
src/sqh_if.sv
src/sqh_div.sv
src/sqh_mul.sv
src/scale_quantizer_hysteresis_core.sv
tb/tb_top.sv
